// ===== hdl/stack_machine_execute_unit_defines.svh =====
// Assertion macros used by the execute unit controller.
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SMEU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SMEU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/smeu_pkg.sv =====
package smeu_pkg;

  localparam int HEAP_WORDS         = 4096;
  localparam int DATA_STACK_DEPTH   = 1024;
  localparam int RETURN_STACK_DEPTH = 256;
  localparam int LABEL_COUNT        = 65536;

  localparam int HP_AW  = $clog2(HEAP_WORDS);
  localparam int DS_AW  = $clog2(DATA_STACK_DEPTH);
  localparam int DS_DW  = $clog2(DATA_STACK_DEPTH + 1);
  localparam int RS_AW  = $clog2(RETURN_STACK_DEPTH);
  localparam int RS_DW  = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int LAB_AW = $clog2(LABEL_COUNT);

  localparam int OP_W   = 5;
  localparam int WORD_W = 64;
  localparam int ADDR_W = 16;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 3;

  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 5'd0,  OP_DUP   = 5'd1,  OP_SWAP  = 5'd2,  OP_DROP  = 5'd3,
    OP_ADD   = 5'd4,  OP_SUB   = 5'd5,  OP_MUL   = 5'd6,  OP_DIV   = 5'd7,
    OP_MOD   = 5'd8,  OP_STORE = 5'd9,  OP_FETCH = 5'd10, OP_OUTC  = 5'd11,
    OP_OUTD  = 5'd12, OP_INC   = 5'd13, OP_IND   = 5'd14, OP_MARK  = 5'd15,
    OP_CALL  = 5'd16, OP_JMP   = 5'd17, OP_JZ    = 5'd18, OP_JN    = 5'd19,
    OP_RET   = 5'd20, OP_END   = 5'd21, OP_DEFLAB = 5'd22
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_LABEL   = 3'd1,
    ST_UNDER   = 3'd2,
    ST_OVER    = 3'd3,
    ST_RSTACK  = 3'd4,
    ST_HEAP    = 3'd5,
    ST_DIVZERO = 3'd6
  } status_e;

  typedef struct packed {
    logic       clear;
    logic       accept;
    logic       rd1;
    logic       rd2;
    logic       exec;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       div_start;
    logic       div_cap;
    logic       wb;
    logic       wb2;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic go_mul;
    logic go_div;
    logic go_swap;
    logic div_done;
  } sts_t;

  function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic heap_ok(input logic [WORD_W-1:0] v);
    return !v[WORD_W-1] && (v < WORD_W'(HEAP_WORDS));
  endfunction

endpackage

// ===== hdl/smeu_if.sv =====
interface smeu_in_if;
  import smeu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [WORD_W-1:0] imm;
  logic [ADDR_W-1:0]        label;
  logic [ADDR_W-1:0]        next_addr;
  logic [BYTE_W-1:0]        in_byte;

  modport source (output valid, op, imm, label, next_addr, in_byte, input ready);
  modport sink   (input valid, op, imm, label, next_addr, in_byte, output ready);
endinterface

interface smeu_out_if;
  import smeu_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] next_pc;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              halted;
  logic [STAT_W-1:0] status;

  modport source (output valid, next_pc, out_valid, out_byte, halted, status, input ready);
  modport sink   (input valid, next_pc, out_valid, out_byte, halted, status, output ready);
endinterface

// ===== hdl/smeu_ram.sv =====
module smeu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/smeu_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module smeu_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [smeu_pkg::WORD_W-1:0]   dividend_i,
  input  logic [smeu_pkg::WORD_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [smeu_pkg::WORD_W-1:0]   quot_o,
  output logic [smeu_pkg::WORD_W-1:0]   rem_o
);
  import smeu_pkg::*;

  localparam int CNT_W = $clog2(WORD_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [WORD_W-1:0] quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [WORD_W:0]   shifted, diff;

  always_comb begin
    shifted = {rem_q, quot_q[WORD_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      cnt_d  = CNT_W'(WORD_W);
      busy_d = 1'b1;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[WORD_W]) begin
        rem_d  = diff[WORD_W-1:0];
        quot_d = {quot_q[WORD_W-2:0], 1'b1};
      end else begin
        rem_d  = shifted[WORD_W-1:0];
        quot_d = {quot_q[WORD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

// ===== hdl/smeu_ctrl.sv =====
module smeu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output smeu_pkg::cmd_t cmd_o,
  input  smeu_pkg::sts_t sts_i
);
  import smeu_pkg::*;
  `include "stack_machine_execute_unit_defines.svh"

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_MUL0, S_MUL1, S_MUL2,
    S_DSTART, S_DWAIT, S_WB, S_WB2, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_v_q, out_v_d;
  logic   in_acc;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == S_IDLE);
    in_acc     = in_ready_o && in_valid_i;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.accept = 1'b1;
          state_d      = S_RD1;
        end
      end
      S_RD1: begin
        cmd_o.rd1 = 1'b1;
        state_d   = S_RD2;
      end
      S_RD2: begin
        cmd_o.rd2 = 1'b1;
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.go_mul)      state_d = S_MUL0;
        else if (sts_i.go_div) state_d = S_DSTART;
        else                   state_d = S_WB;
      end
      S_MUL0: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = 2'd0;
        state_d        = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = 2'd1;
        state_d        = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = 2'd2;
        state_d        = S_WB;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_cap = 1'b1;
          state_d       = S_WB;
        end
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = sts_i.go_swap ? S_WB2 : S_FIN;
      end
      S_WB2: begin
        cmd_o.wb2 = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (!out_v_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_v_d = cmd_o.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

  assign out_valid_o = out_v_q;

  `SMEU_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready_o, "ready right after accept")
  `SMEU_ASSERT_NOW(a_no_overwrite, cmd_o.load_out, !out_v_q || out_ready_i,
                   "result overwritten before taken")
  `SMEU_ASSERT_NOW(a_clear_blocks, state_q == S_CLEAR, !in_ready_o,
                   "input taken during label clear")
endmodule

// ===== hdl/smeu_dp.sv =====
module smeu_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  smeu_pkg::cmd_t                     cmd_i,
  output smeu_pkg::sts_t                     sts_o,
  input  logic [smeu_pkg::OP_W-1:0]          op_i,
  input  logic signed [smeu_pkg::WORD_W-1:0] imm_i,
  input  logic [smeu_pkg::ADDR_W-1:0]        label_i,
  input  logic [smeu_pkg::ADDR_W-1:0]        next_addr_i,
  input  logic [smeu_pkg::BYTE_W-1:0]        in_byte_i,
  output logic [smeu_pkg::ADDR_W-1:0]        next_pc_o,
  output logic                               out_valid_o,
  output logic [smeu_pkg::BYTE_W-1:0]        out_byte_o,
  output logic                               halted_o,
  output logic [smeu_pkg::STAT_W-1:0]        status_o
);
  import smeu_pkg::*;

  // latched item
  op_e               op_q;
  logic [WORD_W-1:0] imm_q;
  logic [ADDR_W-1:0] lab_q, fall_q;
  logic [BYTE_W-1:0] ib_q;
  // operands
  logic [WORD_W-1:0] a_q, b_q, heap_q, res_q, res_d;
  logic [ADDR_W-1:0] dest_q, ret_q, pc_q, pc_d;
  logic [BYTE_W-1:0] ch_q, ch_d;
  logic              chv_q, chv_d;
  status_e           err_q, err_d;
  // control state
  logic [DS_DW-1:0]  ddep_q, ddep_d;
  logic [RS_DW-1:0]  rdep_q, rdep_d;
  logic              halt_q, halt_d;
  status_e           stat_q, stat_d;
  logic [LAB_AW-1:0] clr_q;

  logic [DS_DW-1:0]  dm1, dm2;
  logic [RS_DW-1:0]  rm1;
  logic              lab_ok, ok;
  logic [BYTE_W-1:0] ind_b;

  // memories
  logic              ds_we, hp_we, rs_we, lt_we;
  logic [DS_AW-1:0]  ds_waddr, ds_raddr;
  logic [WORD_W-1:0] ds_wdata, ds_rdata, hp_wdata, hp_rdata;
  logic [HP_AW-1:0]  hp_waddr;
  logic [LAB_AW-1:0] lt_waddr;
  logic [ADDR_W-1:0] lt_wdata, lt_rdata, rs_rdata;

  // multiplier and divider
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic              div_done;
  logic [WORD_W-1:0] div_q, div_r;

  assign dm1   = ddep_q - 1'b1;
  assign dm2   = ddep_q - DS_DW'(2);
  assign rm1   = rdep_q - 1'b1;
  assign ind_b = ib_q - CH_ZERO;
  assign ok    = (err_q == ST_OK) && !halt_q;
  assign lab_ok = ({16'd0, lab_q} < 32'(LABEL_COUNT)) && (dest_q != '0);

  assign ds_raddr = cmd_i.rd1 ? dm2[DS_AW-1:0] : dm1[DS_AW-1:0];

  smeu_ram #(.WIDTH(WORD_W), .DEPTH(DATA_STACK_DEPTH)) u_dstack (
    .clk_i, .we_i(ds_we), .waddr_i(ds_waddr), .wdata_i(ds_wdata),
    .raddr_i(ds_raddr), .rdata_o(ds_rdata));

  // heap is read with the top of stack straight from the stack RAM
  smeu_ram #(.WIDTH(WORD_W), .DEPTH(HEAP_WORDS)) u_heap (
    .clk_i, .we_i(hp_we), .waddr_i(hp_waddr), .wdata_i(hp_wdata),
    .raddr_i(ds_rdata[HP_AW-1:0]), .rdata_o(hp_rdata));

  smeu_ram #(.WIDTH(ADDR_W), .DEPTH(RETURN_STACK_DEPTH)) u_rstack (
    .clk_i, .we_i(rs_we), .waddr_i(rdep_q[RS_AW-1:0]), .wdata_i(fall_q),
    .raddr_i(rm1[RS_AW-1:0]), .rdata_o(rs_rdata));

  smeu_ram #(.WIDTH(ADDR_W), .DEPTH(LABEL_COUNT)) u_labels (
    .clk_i, .we_i(lt_we), .waddr_i(lt_waddr), .wdata_i(lt_wdata),
    .raddr_i(label_i[LAB_AW-1:0]), .rdata_o(lt_rdata));

  smeu_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(mag(a_q)),
    .divisor_i(mag(b_q)), .done_o(div_done), .quot_o(div_q), .rem_o(div_r));

  always_comb begin
    case (cmd_i.mul_step)
      2'd0:    begin mul_a = a_q[31:0];  mul_b = b_q[31:0];  end
      2'd1:    begin mul_a = a_q[31:0];  mul_b = b_q[63:32]; end
      default: begin mul_a = a_q[63:32]; mul_b = b_q[31:0];  end
    endcase
    prod = {32'd0, mul_a} * {32'd0, mul_b};
  end

  // execute: faults and simple results
  always_comb begin
    err_d = ST_OK;
    res_d = '0;
    pc_d  = fall_q;
    ch_d  = '0;
    chv_d = 1'b0;
    case (op_q)
      OP_PUSH: begin
        if (ddep_q >= DS_DW'(DATA_STACK_DEPTH)) err_d = ST_OVER;
        res_d = imm_q;
      end
      OP_DUP: begin
        if (ddep_q < DS_DW'(1))                      err_d = ST_UNDER;
        else if (ddep_q >= DS_DW'(DATA_STACK_DEPTH)) err_d = ST_OVER;
        res_d = b_q;
      end
      OP_SWAP, OP_MUL: begin
        if (ddep_q < DS_DW'(2)) err_d = ST_UNDER;
      end
      OP_DROP: begin
        if (ddep_q < DS_DW'(1)) err_d = ST_UNDER;
      end
      OP_ADD, OP_SUB: begin
        if (ddep_q < DS_DW'(2)) err_d = ST_UNDER;
        res_d = (op_q == OP_ADD) ? a_q + b_q : a_q - b_q;
      end
      OP_DIV, OP_MOD: begin
        if (ddep_q < DS_DW'(2)) err_d = ST_UNDER;
        else if (b_q == '0)     err_d = ST_DIVZERO;
      end
      OP_STORE: begin
        if (ddep_q < DS_DW'(2)) err_d = ST_UNDER;
        else if (!heap_ok(a_q)) err_d = ST_HEAP;
      end
      OP_FETCH: begin
        if (ddep_q < DS_DW'(1)) err_d = ST_UNDER;
        else if (!heap_ok(b_q)) err_d = ST_HEAP;
        res_d = heap_q;
      end
      OP_OUTC, OP_OUTD: begin
        if (ddep_q < DS_DW'(1)) err_d = ST_UNDER;
        ch_d  = (op_q == OP_OUTD) ? b_q[7:0] + CH_ZERO : b_q[7:0];
        chv_d = 1'b1;
      end
      OP_INC, OP_IND: begin
        if (ddep_q < DS_DW'(1)) err_d = ST_UNDER;
        else if (!heap_ok(b_q)) err_d = ST_HEAP;
        res_d = (op_q == OP_IND) ? {{56{ind_b[7]}}, ind_b} : {{56{ib_q[7]}}, ib_q};
      end
      OP_CALL: begin
        if (!lab_ok)                                     err_d = ST_LABEL;
        else if (rdep_q >= RS_DW'(RETURN_STACK_DEPTH))   err_d = ST_RSTACK;
        pc_d = dest_q;
      end
      OP_JMP: begin
        if (!lab_ok) err_d = ST_LABEL;
        pc_d = dest_q;
      end
      OP_JZ, OP_JN: begin
        if (!lab_ok)                 err_d = ST_LABEL;
        else if (ddep_q < DS_DW'(1)) err_d = ST_UNDER;
        if ((op_q == OP_JZ) ? (b_q == '0) : b_q[WORD_W-1]) pc_d = dest_q;
      end
      OP_RET: begin
        if (rdep_q == '0) err_d = ST_RSTACK;
        pc_d = ret_q;
      end
      default: ;
    endcase
    if (halt_q) err_d = ST_OK;
    if (err_d != ST_OK || halt_q) begin
      pc_d  = fall_q;
      ch_d  = '0;
      chv_d = 1'b0;
    end
  end

  assign sts_o.clr_last = (clr_q == LAB_AW'(LABEL_COUNT - 1));
  assign sts_o.go_mul   = (op_q == OP_MUL) && (err_d == ST_OK) && !halt_q;
  assign sts_o.go_div   = ((op_q == OP_DIV) || (op_q == OP_MOD)) && (err_d == ST_OK) && !halt_q;
  assign sts_o.go_swap  = (op_q == OP_SWAP) && ok;
  assign sts_o.div_done = div_done;

  // write back
  always_comb begin
    ds_we    = 1'b0;
    ds_waddr = dm1[DS_AW-1:0];
    ds_wdata = res_q;
    hp_we    = 1'b0;
    hp_waddr = b_q[HP_AW-1:0];
    hp_wdata = res_q;
    rs_we    = 1'b0;
    lt_we    = cmd_i.clear;
    lt_waddr = clr_q;
    lt_wdata = '0;
    ddep_d   = ddep_q;
    rdep_d   = rdep_q;
    halt_d   = halt_q;
    stat_d   = stat_q;
    if (cmd_i.wb2) begin
      ds_we    = 1'b1;
      ds_waddr = dm2[DS_AW-1:0];
      ds_wdata = b_q;
    end
    if (cmd_i.wb && !halt_q && err_q != ST_OK) begin
      halt_d = 1'b1;
      stat_d = err_q;
    end
    if (cmd_i.wb && ok) begin
      case (op_q)
        OP_PUSH, OP_DUP: begin
          ds_we    = 1'b1;
          ds_waddr = ddep_q[DS_AW-1:0];
          ddep_d   = ddep_q + 1'b1;
        end
        OP_SWAP: begin
          ds_we    = 1'b1;
          ds_wdata = a_q;
        end
        OP_DROP, OP_OUTC, OP_OUTD, OP_JZ, OP_JN: ddep_d = dm1;
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
          ds_we    = 1'b1;
          ds_waddr = dm2[DS_AW-1:0];
          ddep_d   = dm1;
        end
        OP_STORE: begin
          hp_we    = 1'b1;
          hp_waddr = a_q[HP_AW-1:0];
          hp_wdata = b_q;
          ddep_d   = dm2;
        end
        OP_FETCH: ds_we = 1'b1;
        OP_INC, OP_IND: begin
          hp_we  = 1'b1;
          ddep_d = dm1;
        end
        OP_CALL: begin
          rs_we  = 1'b1;
          rdep_d = rdep_q + 1'b1;
        end
        OP_RET: rdep_d = rm1;
        OP_END: halt_d = 1'b1;
        OP_DEFLAB: begin
          lt_we    = {16'd0, lab_q} < 32'(LABEL_COUNT);
          lt_waddr = lab_q[LAB_AW-1:0];
          lt_wdata = fall_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ddep_q <= '0;
      rdep_q <= '0;
      halt_q <= 1'b0;
      stat_q <= ST_OK;
      clr_q  <= '0;
      err_q  <= ST_OK;
    end else begin
      ddep_q <= ddep_d;
      rdep_q <= rdep_d;
      halt_q <= halt_d;
      stat_q <= stat_d;
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
      if (cmd_i.exec)  err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_e'(op_i);
      imm_q  <= imm_i;
      lab_q  <= label_i;
      fall_q <= next_addr_i;
      ib_q   <= in_byte_i;
    end
    if (cmd_i.rd1) begin
      b_q    <= ds_rdata;
      dest_q <= lt_rdata;
      ret_q  <= rs_rdata;
    end
    if (cmd_i.rd2) begin
      a_q    <= ds_rdata;
      heap_q <= hp_rdata;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
      pc_q  <= pc_d;
      ch_q  <= ch_d;
      chv_q <= chv_d;
    end
    if (cmd_i.mul_en) begin
      res_q <= (cmd_i.mul_step == 2'd0) ? prod : res_q + {prod[31:0], 32'd0};
    end
    if (cmd_i.div_cap) begin
      if (op_q == OP_DIV) begin
        res_q <= (a_q[WORD_W-1] ^ b_q[WORD_W-1]) ? ~div_q + 1'b1 : div_q;
      end else begin
        res_q <= div_r;
      end
    end
    if (cmd_i.load_out) begin
      next_pc_o   <= pc_q;
      out_valid_o <= chv_q;
      out_byte_o  <= ch_q;
      halted_o    <= halt_q;
      status_o    <= stat_q;
    end
  end
endmodule

// ===== hdl/stack_machine_execute_unit.sv =====
// Channel  Dir  Payload                                          Role
// in_i     in   op, imm, label, next_addr, in_byte               one decoded instruction
// res_o    out  next_pc, out_valid, out_byte, halted, status     one result per instruction
//
// Steps: accept, two stack reads, execute, write back, result load; mul adds
//   MUL0-MUL2 on a shared 32x32 multiplier, div/mod waits on the divider (one
//   quotient bit per cycle), swap a second write back (single stack write port).
// Reset: label table is swept to zero, one entry per cycle, all 65536 entries;
//   in_i.ready stays low until the sweep finishes.
// Stalls: a result waits in the output register; the next transaction is
//   taken meanwhile, its result waits until res_o is free.
module stack_machine_execute_unit (
  input  logic clk_i,
  input  logic rst_ni,
  smeu_in_if.sink    in_i,
  smeu_out_if.source res_o
);
  import smeu_pkg::*;

  cmd_t cmd;   // controller to datapath
  sts_t sts;   // datapath to controller

  // sequencing: clear sweep, operand fetch, execute, mul/div steps, write back, result load
  smeu_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // stacks, heap, label table and arithmetic
  smeu_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (in_i.op),
    .imm_i       (in_i.imm),
    .label_i     (in_i.label),
    .next_addr_i (in_i.next_addr),
    .in_byte_i   (in_i.in_byte),
    .next_pc_o   (res_o.next_pc),
    .out_valid_o (res_o.out_valid),
    .out_byte_o  (res_o.out_byte),
    .halted_o    (res_o.halted),
    .status_o    (res_o.status)
  );
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import smeu_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] imm;
    logic [ADDR_W-1:0] label;
    logic [ADDR_W-1:0] next_addr;
    logic [BYTE_W-1:0] in_byte;
  } instr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_pc;
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              halted;
    logic [STAT_W-1:0] status;
  } step_res_t;

  localparam logic [WORD_W-1:0] MIN_WORD = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] MAX_WORD = {1'b0, {(WORD_W-1){1'b1}}};

  logic clk;
  logic rst_n;

  smeu_in_if  in_if ();
  smeu_out_if res_if ();

  stack_machine_execute_unit uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .res_o (res_if.source)
  );

  // ---------------------------------------------------------------------------
  // Shadow machine state: our own copy of the stacks, heap and label table.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] shadow_ds   [DATA_STACK_DEPTH];
  int                ds_depth;
  logic [ADDR_W-1:0] shadow_rs   [RETURN_STACK_DEPTH];
  int                rs_depth;
  logic [WORD_W-1:0] shadow_heap [HEAP_WORDS];
  bit                heap_written[HEAP_WORDS];
  int                written_addrs[$];
  logic [ADDR_W-1:0] shadow_labels[LABEL_COUNT];
  int                defined_labels[$];
  bit                shadow_halted;
  logic [STAT_W-1:0] latched_stat;

  step_res_t pending_results[$];   // expected results, oldest first
  int        sent_count;
  int        result_count;
  int        mismatches;
  int        out_chars;
  bit        quiet;                // no idling on either side
  int        fault_kind;

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // hard limit: label sweep after reset plus a slow run, taken many times over
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic bit addr_in_heap(input logic [WORD_W-1:0] v);
    return !v[WORD_W-1] && (v < WORD_W'(HEAP_WORDS));
  endfunction

  function automatic logic [WORD_W-1:0] sign_ext_byte(input logic [BYTE_W-1:0] v);
    return {{(WORD_W-BYTE_W){v[BYTE_W-1]}}, v};
  endfunction

  // Executes one instruction on the shadow state. With commit low the state
  // is left alone and only the outcome is worked out.
  task automatic execute_instr(input instr_t it, input bit commit, output step_res_t r);
    logic [WORD_W-1:0] a, b, q;
    logic [ADDR_W-1:0] pc, dest;
    logic [BYTE_W-1:0] ch;
    logic [STAT_W-1:0] err;
    bit vld, stop;
    int d;
    pc   = it.next_addr;
    ch   = '0;
    vld  = 1'b0;
    err  = ST_OK;
    stop = 1'b0;
    d    = ds_depth;
    dest = shadow_labels[it.label];
    a    = (d >= 2) ? shadow_ds[d-2] : '0;
    b    = (d >= 1) ? shadow_ds[d-1] : '0;
    if (shadow_halted) begin
      r = '{next_pc: it.next_addr, out_valid: 1'b0, out_byte: '0, halted: 1'b1,
            status: latched_stat};
      return;
    end
    case (it.op)
      OP_PUSH, OP_DUP: begin
        if (it.op == OP_DUP && d < 1) err = ST_UNDER;
        else if (d >= DATA_STACK_DEPTH) err = ST_OVER;
        else if (commit) begin
          shadow_ds[d] = (it.op == OP_PUSH) ? it.imm : b;
          ds_depth = d + 1;
        end
      end
      OP_SWAP: begin
        if (d < 2) err = ST_UNDER;
        else if (commit) begin
          shadow_ds[d-1] = a;
          shadow_ds[d-2] = b;
        end
      end
      OP_DROP: begin
        if (d < 1) err = ST_UNDER;
        else if (commit) ds_depth = d - 1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        if (d < 2) err = ST_UNDER;
        else if ((it.op == OP_DIV || it.op == OP_MOD) && b == '0) err = ST_DIVZERO;
        else begin
          case (it.op)
            OP_ADD: a = a + b;
            OP_SUB: a = a - b;
            OP_MUL: a = a * b;
            OP_DIV: begin
              // truncating: divide magnitudes, then fix the sign
              q = magnitude(a) / magnitude(b);
              a = (a[WORD_W-1] ^ b[WORD_W-1]) ? (~q + 1'b1) : q;
            end
            default: a = magnitude(a) % magnitude(b);
          endcase
          if (commit) begin
            shadow_ds[d-2] = a;
            ds_depth = d - 1;
          end
        end
      end
      OP_STORE: begin
        if (d < 2) err = ST_UNDER;
        else if (!addr_in_heap(a)) err = ST_HEAP;
        else if (commit) begin
          if (!heap_written[a]) written_addrs.push_back(int'(a));
          heap_written[a] = 1'b1;
          shadow_heap[a]  = b;
          ds_depth = d - 2;
        end
      end
      OP_FETCH: begin
        if (d < 1) err = ST_UNDER;
        else if (!addr_in_heap(b)) err = ST_HEAP;
        else if (commit) shadow_ds[d-1] = shadow_heap[b];
      end
      OP_OUTC, OP_OUTD: begin
        if (d < 1) err = ST_UNDER;
        else begin
          ch  = (it.op == OP_OUTD) ? (b[BYTE_W-1:0] + CH_ZERO) : b[BYTE_W-1:0];
          vld = 1'b1;
          if (commit) ds_depth = d - 1;
        end
      end
      OP_INC, OP_IND: begin
        if (d < 1) err = ST_UNDER;
        else if (!addr_in_heap(b)) err = ST_HEAP;
        else if (commit) begin
          if (!heap_written[b]) written_addrs.push_back(int'(b));
          heap_written[b] = 1'b1;
          shadow_heap[b]  = sign_ext_byte((it.op == OP_IND) ? (it.in_byte - CH_ZERO)
                                                            : it.in_byte);
          ds_depth = d - 1;
        end
      end
      OP_CALL: begin
        if (dest == '0) err = ST_LABEL;
        else if (rs_depth >= RETURN_STACK_DEPTH) err = ST_RSTACK;
        else begin
          pc = dest;
          if (commit) begin
            shadow_rs[rs_depth] = it.next_addr;
            rs_depth++;
          end
        end
      end
      OP_JMP: begin
        if (dest == '0) err = ST_LABEL;
        else pc = dest;
      end
      OP_JZ, OP_JN: begin
        // label is looked up before the stack
        if (dest == '0) err = ST_LABEL;
        else if (d < 1) err = ST_UNDER;
        else begin
          if ((it.op == OP_JZ) ? (b == '0) : b[WORD_W-1]) pc = dest;
          if (commit) ds_depth = d - 1;
        end
      end
      OP_RET: begin
        if (rs_depth == 0) err = ST_RSTACK;
        else begin
          pc = shadow_rs[rs_depth-1];
          if (commit) rs_depth--;
        end
      end
      OP_END: stop = 1'b1;
      OP_DEFLAB: begin
        if (commit) begin
          shadow_labels[it.label] = it.next_addr;
          defined_labels.push_back(int'(it.label));
        end
      end
      default: ;  // mark and unused codes fall through
    endcase
    if (err != ST_OK) begin
      pc   = it.next_addr;
      vld  = 1'b0;
      ch   = '0;
      stop = 1'b1;
    end
    if (commit && stop) begin
      shadow_halted = 1'b1;
      if (err != ST_OK) latched_stat = err;
    end
    r = '{next_pc: pc, out_valid: vld, out_byte: ch, halted: stop,
          status: (err != ST_OK) ? err : latched_stat};
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one instruction per call, with random idle bursts before it.
  // ---------------------------------------------------------------------------
  task automatic send_instr(input instr_t it);
    step_res_t r;
    bit hit;
    execute_instr(it, 1'b1, r);
    pending_results.push_back(r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= it.op;
    in_if.imm       <= it.imm;
    in_if.label     <= it.label;
    in_if.next_addr <= it.next_addr;
    in_if.in_byte   <= it.in_byte;
    // ready is sampled mid-cycle, the transaction happens at the next edge
    forever begin
      @(negedge clk);
      hit = in_if.ready;
      @(posedge clk);
      if (hit) break;
    end
    sent_count++;
  endtask

  function automatic instr_t make_instr(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] imm,
                                        input logic [ADDR_W-1:0] lab,
                                        input logic [BYTE_W-1:0] ib);
    instr_t it;
    it.op        = op;
    it.imm       = imm;
    it.label     = lab;
    it.next_addr = ADDR_W'($urandom);
    it.in_byte   = ib;
    return it;
  endfunction

  task automatic issue(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] imm = '0,
                       input logic [ADDR_W-1:0] lab = '0, input logic [BYTE_W-1:0] ib = '0);
    send_instr(make_instr(op, imm, lab, ib));
  endtask

  // Sends an instruction only when it cannot fault; otherwise a harmless
  // push or drop goes in its place, so the program keeps running.
  task automatic issue_safe(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] imm = '0,
                            input logic [ADDR_W-1:0] lab = '0,
                            input logic [BYTE_W-1:0] ib = '0);
    instr_t it;
    step_res_t r;
    bit bad;
    it = make_instr(op, imm, lab, ib);
    execute_instr(it, 1'b0, r);
    bad = r.halted;
    if (op == OP_FETCH && ds_depth >= 1 && addr_in_heap(shadow_ds[ds_depth-1]))
      bad |= !heap_written[shadow_ds[ds_depth-1]];
    if (bad) begin
      if (ds_depth >= DATA_STACK_DEPTH - 24) it = make_instr(OP_DROP, '0, '0, '0);
      else it = make_instr(OP_PUSH, WORD_W'($urandom_range(1, 300)), '0, '0);
    end
    send_instr(it);
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return MIN_WORD;
      1: return MAX_WORD;
      2: return '1;
      3: return '0;
      4, 5: return WORD_W'($urandom_range(0, 200)) - 64'd100;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_heap_addr();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return WORD_W'(HEAP_WORDS - 1);
      2, 3: return WORD_W'($urandom_range(0, 31));
      default: return WORD_W'($urandom_range(0, HEAP_WORDS - 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, and a check of every transaction.
  // ---------------------------------------------------------------------------
  initial begin
    step_res_t got, want;
    bit take;
    int stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      take = res_if.valid && res_if.ready;
      got  = '{next_pc: res_if.next_pc, out_valid: res_if.out_valid,
               out_byte: res_if.out_byte, halted: res_if.halted, status: res_if.status};
      @(posedge clk);
      if (take) begin
        result_count++;
        if (got.out_valid) out_chars++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got.next_pc !== want.next_pc || got.out_valid !== want.out_valid ||
              got.out_byte !== want.out_byte || got.halted !== want.halted ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: expected %p, got %p",
                       result_count, want, got);
          end
        end
      end
      if (!rst_n) res_if.ready <= 1'b0;
      else if (quiet) res_if.ready <= 1'b1;
      else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        res_if.ready <= 1'b0;
      end else res_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Directed: operand extremes, every op but add, drop and end, label corner cases.
  task automatic test_directed_ops();
    issue(OP_DEFLAB, '0, 16'hFFFF);
    issue(OP_DEFLAB, '0, 16'h0000);        // next_addr forced below
    send_instr('{op: OP_DEFLAB, imm: '0, label: 16'h0003, next_addr: 16'h0000, in_byte: '0});
    send_instr('{op: OP_DEFLAB, imm: '0, label: 16'h0007, next_addr: 16'hFFFF, in_byte: '0});
    issue(OP_PUSH, MIN_WORD);
    issue(OP_PUSH, '1);
    issue(OP_DIV);                         // most negative / -1 wraps
    issue(OP_PUSH, MAX_WORD);
    issue(OP_MUL);
    issue(OP_PUSH, -64'sd7);
    issue(OP_PUSH, 64'd2);
    issue(OP_MOD);                         // negative dividend, result positive
    issue(OP_SUB);
    issue(OP_OUTC);
    issue(OP_PUSH, WORD_W'(HEAP_WORDS - 1));
    issue(OP_PUSH, '0);
    issue(OP_SWAP);
    issue(OP_STORE);                       // heap[0] = top heap address
    issue(OP_PUSH, '0);
    issue(OP_FETCH);
    issue(OP_DUP);
    issue(OP_OUTD);
    issue(OP_INC, '0, '0, 8'hFF);          // top heap word = -1
    issue(OP_PUSH, WORD_W'(HEAP_WORDS - 1));
    issue(OP_FETCH);
    issue(OP_JN, '0, 16'h0007);            // taken
    issue(OP_PUSH, 64'd1);
    issue(OP_IND, '0, '0, 8'h00);          // '0' offset wraps below zero
    issue(OP_CALL, '0, 16'hFFFF);
    issue(OP_RET);
    issue(OP_JMP, '0, 16'h0007);
    issue(OP_PUSH, '0);
    issue(OP_JZ, '0, 16'hFFFF);            // taken
    issue(OP_MARK);
    issue(5'd31);                          // unused code
  endtask

  // Random well-formed program fragments with random content.
  task automatic test_random_program(input int n_items);
    int start, sel, idx;
    logic [OP_W-1:0] op;
    logic [ADDR_W-1:0] lab;
    start = sent_count;
    while (sent_count - start < n_items) begin
      quiet = (sent_count - start) > (n_items * 4 / 5);
      sel = $urandom_range(0, 99);
      if (ds_depth > 900 && sel < 30) sel = 32;
      if (sel < 20) issue_safe(OP_PUSH, rand_word());
      else if (sel < 30) begin
        if (ds_depth < 2) issue_safe(OP_PUSH, rand_word());
        issue_safe(OP_ADD + OP_W'($urandom_range(0, 4)));
      end else if (sel < 35) issue_safe(OP_DUP + OP_W'($urandom_range(0, 2)));
      else if (sel < 43) begin
        issue_safe(OP_PUSH, rand_heap_addr());
        issue_safe(OP_PUSH, rand_word());
        issue_safe(OP_STORE);
      end else if (sel < 50) begin
        if (written_addrs.size() > 0) begin
          idx = $urandom_range(0, written_addrs.size() - 1);
          issue_safe(OP_PUSH, WORD_W'(written_addrs[idx]));
          issue_safe(OP_FETCH);
        end
      end else if (sel < 56) begin
        issue_safe(OP_PUSH, rand_heap_addr());
        issue_safe($urandom_range(0, 1) ? OP_INC : OP_IND, '0, '0, BYTE_W'($urandom));
      end else if (sel < 61) issue_safe($urandom_range(0, 1) ? OP_OUTC : OP_OUTD);
      else if (sel < 67) begin
        if ($urandom_range(0, 7) == 0)
          send_instr('{op: OP_DEFLAB, imm: '0, label: ADDR_W'($urandom),
                       next_addr: '0, in_byte: '0});
        else issue(OP_DEFLAB, '0, ADDR_W'($urandom));
      end else if (sel < 83) begin
        if (defined_labels.size() == 0) issue(OP_DEFLAB, '0, ADDR_W'($urandom));
        else begin
          idx = $urandom_range(0, defined_labels.size() - 1);
          lab = ADDR_W'(defined_labels[idx]);
          op  = OP_CALL + OP_W'($urandom_range(0, 3));
          if (op == OP_JZ && $urandom_range(0, 1)) issue_safe(OP_PUSH, '0);
          if (op == OP_CALL && rs_depth >= RETURN_STACK_DEPTH) op = OP_RET;
          issue_safe(op, '0, lab);
        end
      end else if (sel < 89) begin
        if (rs_depth > 0) issue_safe(OP_RET);
      end else if (sel < 94) begin
        issue_safe($urandom_range(0, 1) ? OP_MARK : OP_W'($urandom_range(23, 31)),
                   rand_word(), ADDR_W'($urandom), BYTE_W'($urandom));
      end else issue_safe(OP_PUSH, WORD_W'($urandom_range(0, 9)));
    end
    quiet = 1'b0;
  endtask

  // The sender holds off until every outstanding result has come back.
  task automatic test_drain_pause();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    test_random_program(20);
  endtask

  // One halting event per run (reset is never repeated), then ignored items.
  // This is the tail of the run, so both sides run without idling.
  task automatic test_halt();
    int k;
    logic [ADDR_W-1:0] lab;
    quiet      = 1'b1;
    fault_kind = $urandom_range(0, 6);
    case (fault_kind)
      0: issue(OP_END);
      1: begin
        do lab = ADDR_W'($urandom); while (shadow_labels[lab] != '0);
        issue($urandom_range(0, 1) ? OP_JMP : OP_JZ, '0, lab);
      end
      2: begin
        while (ds_depth > 0) issue(OP_DROP);
        issue(OP_ADD + OP_W'($urandom_range(0, 4)));
      end
      3: begin
        while (ds_depth < DATA_STACK_DEPTH) issue(OP_PUSH, rand_word());
        issue($urandom_range(0, 1) ? OP_PUSH : OP_DUP, rand_word());
      end
      4: begin
        while (rs_depth > 0) issue(OP_RET);
        issue(OP_RET);
      end
      5: begin
        issue(OP_PUSH, $urandom_range(0, 1) ? WORD_W'(HEAP_WORDS) : MIN_WORD);
        issue(OP_FETCH);
      end
      default: begin
        issue(OP_PUSH, 64'd7);
        issue(OP_PUSH, '0);
        issue($urandom_range(0, 1) ? OP_DIV : OP_MOD);
      end
    endcase
    for (k = 0; k < 6; k++)
      issue(OP_W'($urandom_range(0, 31)), rand_word(), ADDR_W'($urandom), BYTE_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int wait_cycles;
    in_if.valid     = 1'b0;
    in_if.op        = '0;
    in_if.imm       = '0;
    in_if.label     = '0;
    in_if.next_addr = '0;
    in_if.in_byte   = '0;
    foreach (shadow_labels[i]) shadow_labels[i] = '0;
    ds_depth      = 0;
    rs_depth      = 0;
    shadow_halted = 1'b0;
    latched_stat  = ST_OK;
    sent_count    = 0;
    result_count  = 0;
    mismatches    = 0;
    out_chars     = 0;
    quiet         = 1'b0;

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    test_directed_ops();
    test_random_program(260);
    test_drain_pause();
    test_random_program(270);
    test_halt();

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // room for a stray extra result; div/mod is the slowest instruction
    wait_cycles = 0;
    while (wait_cycles < 200) begin
      @(posedge clk);
      wait_cycles++;
    end

    $display("Ran %0d instructions (%0d output chars), halting case %0d at end;",
             sent_count, out_chars, fault_kind);
    $display("checked %0d results, %0d mismatches.", result_count, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/smeu_pkg.sv
hdl/smeu_if.sv
hdl/smeu_ram.sv
hdl/smeu_div.sv
hdl/smeu_ctrl.sv
hdl/smeu_dp.sv
hdl/stack_machine_execute_unit.sv
sim/testbench.sv
